// File: src/lmht_pkg.sv
// shared types, constants and helpers for the lock monitor hash table
`timescale 1ns / 1ps
`default_nettype none
package lmht_pkg;
    localparam int POOL_ENTRIES = 64;
    localparam int BUCKETS      = 32;
    localparam int COUNT_BITS   = 16;
    localparam int HW           = $clog2(POOL_ENTRIES);
    localparam int PW           = HW + 1;
    localparam int BW           = $clog2(BUCKETS);
    localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_CREATE  = 2'd1,
        CMD_DESTROY = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_CREATED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BUSY      = 3'd3,
        ST_FULL      = 3'd4,
        ST_FREED     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_LU_RD, S_LU_CHK, S_HEAD_RD, S_WALK_RD, S_WALK_CHK,
        S_HIT, S_MISS, S_H_RD, S_H_CHK, S_UL_RD, S_UL_CHK, S_FREE, S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input transaction
        logic rd_lu;      // read entry at last_used
        logic rd_head;    // read bucket head
        logic rd_cur;     // read entry at cursor
        logic rd_h;       // read entry at handle
        logic adv;        // cursor <= next, prev <= cursor
        logic hit;        // walk hit: finish lookup / create-hit
        logic lu_hit;     // last-used hit
        logic miss;       // walk miss
        logic h_chk;      // evaluate destroy / release on handle entry
        logic do_free;    // unlink done, free entry
        logic ul_fix;     // patch link of predecessor or head
        logic done;       // result valid
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic lu_match;
        logic cur_nil;
        logic cur_match;
        logic cur_is_h;
        logic steps_out;
        logic h_free_ok;  // destroy with zero count and valid match
    } t_sts;

    function automatic logic [BW-1:0] bucket_of(input logic [31:0] k);
        logic [31:0] x;
        x = (k >> 2) ^ (k >> 10);
        return x[BW-1:0];
    endfunction
endpackage
`default_nettype wire

// File: src/lock_monitor_hash_table.sv
// top level of the lock monitor hash table
// usage:
// - command channel i_valid/o_ready carries cmd, key and handle
// - result channel o_valid/i_ready carries status, found handle, use count
//   and the low-free flag; one result per command
// - one command at a time; a lookup or create tries the last-used entry
//   first, then walks the bucket chain; a release, or a destroy that frees
//   nothing, reads only the entry at the handle; a freeing destroy walks
//   the chain up to the entry to unlink it; each entry visited costs a read
//   through the entry ram's registered read port
// - the result register holds until taken; while the receiver stalls no
//   new command is accepted
// - after reset the entry ram is cleared in one pass over all 64 entries,
//   one entry per cycle, with o_ready low; register writes are taken at any time
// - register 0 at address 0 is free_low_threshold, reset 5
`timescale 1ns / 1ps
`default_nettype none
module lock_monitor_hash_table import lmht_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [1:0]            i_cmd,
    input  wire logic [31:0]           i_key,
    input  wire logic [HW-1:0]         i_handle,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [2:0]                 o_status,
    output logic [HW-1:0]              o_found_handle,
    output logic [COUNT_BITS-1:0]      o_use_count,
    output logic                       o_free_low,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [1:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    t_ctl       ctl;
    t_sts       sts;
    logic       busy;
    logic [6:0] r_thr;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thr <= 7'd5;
        else if (psel && penable && pwrite && paddr == 2'd0) r_thr <= pwdata[6:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {25'd0, r_thr} : 32'd0;

    lmht_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_busy(busy), .i_sts(sts),
        .o_ctl(ctl));

    lmht_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_cmd(i_cmd), .i_key(i_key), .i_handle(i_handle), .i_thr(r_thr),
        .o_busy(busy), .o_status(o_status), .o_found_handle(o_found_handle),
        .o_use_count(o_use_count), .o_free_low(o_free_low));
endmodule
`default_nettype wire

// File: src/lmht_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
`timescale 1ns / 1ps
`default_nettype none
module lmht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/lmht_ctrl.sv
// command sequencer of the hash table
`timescale 1ns / 1ps
`default_nettype none
module lmht_ctrl import lmht_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    input  wire logic i_busy,
    input  wire t_sts i_sts,
    output t_ctl      o_ctl
);
    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ready = (r_state == S_IDLE) && !i_busy;
        o_valid = (r_state == S_DONE);
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                o_ctl.load = 1'b1;
                n_state = S_LU_RD;
            end
            S_LU_RD: begin
                unique case (i_sts.cmd)
                    CMD_LOOKUP, CMD_CREATE: begin
                        o_ctl.rd_lu = 1'b1; n_state = S_LU_CHK;
                    end
                    default: begin
                        o_ctl.rd_h = 1'b1; n_state = S_H_CHK;
                    end
                endcase
            end
            S_LU_CHK: if (i_sts.lu_match) begin
                o_ctl.lu_hit = 1'b1; n_state = S_DONE;
            end else begin
                o_ctl.rd_head = 1'b1; n_state = S_HEAD_RD;
            end
            S_HEAD_RD: n_state = S_WALK_RD;
            S_WALK_RD: if (i_sts.cur_nil || i_sts.steps_out) begin
                n_state = S_MISS;
            end else begin
                o_ctl.rd_cur = 1'b1; n_state = S_WALK_CHK;
            end
            S_WALK_CHK: if (i_sts.cur_match) begin
                n_state = S_HIT;
            end else begin
                o_ctl.adv = 1'b1; n_state = S_WALK_RD;
            end
            S_HIT: begin
                o_ctl.hit = 1'b1; n_state = S_DONE;
            end
            S_MISS: begin
                o_ctl.miss = 1'b1; n_state = S_DONE;
            end
            // bucket head read ahead of the unlink walk
            S_H_RD: n_state = S_UL_RD;
            S_H_CHK: begin
                o_ctl.h_chk = 1'b1;
                if (i_sts.cmd == CMD_DESTROY && i_sts.h_free_ok) begin
                    o_ctl.rd_head = 1'b1; n_state = S_H_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UL_RD: if (i_sts.cur_nil || i_sts.steps_out) begin
                n_state = S_FREE;
            end else begin
                o_ctl.rd_cur = 1'b1; n_state = S_UL_CHK;
            end
            S_UL_CHK: if (i_sts.cur_is_h) begin
                o_ctl.ul_fix = 1'b1; n_state = S_FREE;
            end else begin
                o_ctl.adv = 1'b1; n_state = S_UL_RD;
            end
            S_FREE: begin
                o_ctl.do_free = 1'b1; n_state = S_DONE;
            end
            S_DONE: begin
                o_ctl.done = 1'b1;
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result only shows in the done state
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_DONE) else $error("valid outside done");
    // result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    // no accept while working
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready) else $error("accept while busy");
endmodule
`default_nettype wire

// File: src/lmht_dp.sv
// storage and datapath of the hash table
`timescale 1ns / 1ps
`default_nettype none
module lmht_dp import lmht_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_ctl             i_ctl,
    output t_sts                  o_sts,
    input  wire logic [1:0]       i_cmd,
    input  wire logic [31:0]      i_key,
    input  wire logic [HW-1:0]    i_handle,
    input  wire logic [6:0]       i_thr,
    output logic                  o_busy,
    output logic [2:0]            o_status,
    output logic [HW-1:0]         o_found_handle,
    output logic [COUNT_BITS-1:0] o_use_count,
    output logic                  o_free_low
);
    // entry word: key, next, in_use, count
    localparam int EW = 32 + PW + 1 + COUNT_BITS;
    typedef struct packed {
        logic [31:0]         key;
        logic [PW-1:0]       nxt;
        logic                used;
        logic [COUNT_BITS-1:0] cnt;
    } t_ent;

    t_cmd              r_cmd;
    logic [31:0]       r_key;
    logic [HW-1:0]     r_h;
    logic [BW-1:0]     r_b;
    logic [PW-1:0]     r_cur, r_prev, r_free_head, r_last;
    logic [PW:0]       r_steps;
    logic [PW-1:0]     r_free_total;
    logic [BUCKETS-1:0] r_bvalid;
    logic [2:0]        r_status;
    logic [HW-1:0]     r_fh;
    logic [COUNT_BITS-1:0] r_cnt;
    logic              r_clr_busy;
    logic [HW:0]       r_clr;
    t_ent              r_ent;

    logic          e_we, h_we;
    logic [HW-1:0] e_wa, e_ra;
    t_ent          e_wd, e_rd;
    logic [EW-1:0] e_rdw;
    logic [BW-1:0] h_wa;
    logic [PW-1:0] h_wd, h_rd, head;
    logic          rd_any, pend_head, r_pend_head;

    assign e_rd = t_ent'(e_rdw);

    lmht_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_ent (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_wa), .i_wdata(EW'(e_wd)),
        .i_raddr(e_ra), .o_rdata(e_rdw));
    lmht_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(r_b), .o_rdata(h_rd));

    assign head = r_bvalid[r_b] ? h_rd : NIL;
    assign pend_head = i_ctl.rd_head;
    assign o_busy = r_clr_busy;

    // read address select; a finished walk fetches the free-list head
    always_comb begin
        priority if (i_ctl.rd_lu)  e_ra = r_last[HW-1:0];
        else if (i_ctl.rd_h)       e_ra = r_h;
        else if (r_pend_head)      e_ra = head[HW-1:0];
        else if (r_cur == NIL || o_sts.steps_out) e_ra = r_free_head[HW-1:0];
        else                       e_ra = r_cur[HW-1:0];
        rd_any = i_ctl.rd_lu | i_ctl.rd_h | i_ctl.rd_cur;
    end

    // status to controller
    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.lu_match  = (r_last != NIL) && e_rd.used && e_rd.key == r_key;
        o_sts.cur_nil   = (r_cur == NIL);
        o_sts.cur_match = e_rd.used && e_rd.key == r_key;
        o_sts.cur_is_h  = (r_cur == {1'b0, r_h});
        o_sts.steps_out = (r_steps >= (PW+1)'(POOL_ENTRIES));
        o_sts.h_free_ok = e_rd.used && e_rd.key == r_key && e_rd.cnt == '0;
    end

    // memory writes
    always_comb begin
        e_we = 1'b0; e_wa = r_cur[HW-1:0]; e_wd = e_rd;
        h_we = 1'b0; h_wa = r_b; h_wd = e_rd.nxt;
        if (r_clr_busy) begin
            e_we = 1'b1; e_wa = r_clr[HW-1:0];
            e_wd = '0; e_wd.nxt = PW'(r_clr) + PW'(1);
        end else if (i_ctl.lu_hit || i_ctl.hit) begin
            e_wa = i_ctl.lu_hit ? r_last[HW-1:0] : r_cur[HW-1:0];
            if (r_cmd == CMD_CREATE && e_rd.cnt != COUNT_MAX) begin
                e_we = 1'b1; e_wd.cnt = e_rd.cnt + 1'b1;
            end
        end else if (i_ctl.miss && r_cmd == CMD_CREATE && r_free_total != '0
                     && r_free_head != NIL) begin
            e_we = 1'b1; e_wa = r_free_head[HW-1:0];
            e_wd.key = r_key; e_wd.used = 1'b1; e_wd.cnt = COUNT_BITS'(1);
            e_wd.nxt = head;
            h_we = 1'b1; h_wd = r_free_head;
        end else if (i_ctl.h_chk && r_cmd == CMD_RELEASE && e_rd.used
                     && e_rd.cnt != '0) begin
            e_we = 1'b1; e_wa = r_h; e_wd.cnt = e_rd.cnt - 1'b1;
        end else if (i_ctl.ul_fix) begin
            if (r_prev == NIL) begin
                h_we = 1'b1; h_wd = e_rd.nxt;
            end else begin
                e_we = 1'b1; e_wa = r_prev[HW-1:0];
                e_wd = r_ent; e_wd.nxt = e_rd.nxt;
            end
        end else if (i_ctl.do_free) begin
            e_we = 1'b1; e_wa = r_h;
            e_wd = '0; e_wd.nxt = r_free_head;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0; r_free_total <= PW'(POOL_ENTRIES);
            r_last <= NIL; r_bvalid <= '0;
            r_clr_busy <= 1'b1; r_clr <= '0; r_pend_head <= 1'b0;
        end else begin
            r_pend_head <= pend_head;
            if (r_clr_busy) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == (HW+1)'(POOL_ENTRIES-1)) r_clr_busy <= 1'b0;
            end
            if (h_we) r_bvalid[h_wa] <= 1'b1;
            if (i_ctl.hit) r_last <= r_cur;
            if (i_ctl.miss && r_cmd == CMD_CREATE && r_free_total != '0
                && r_free_head != NIL) begin
                r_free_head  <= e_rd.nxt;
                r_free_total <= r_free_total - 1'b1;
            end
            if (i_ctl.do_free) begin
                r_free_head  <= {1'b0, r_h};
                r_free_total <= r_free_total + 1'b1;
                if (r_last == {1'b0, r_h}) r_last <= NIL;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= t_cmd'(i_cmd); r_key <= i_key; r_h <= i_handle;
            r_b <= bucket_of(i_key);
            r_status <= ST_NOT_FOUND; r_fh <= '0; r_cnt <= '0;
        end
        if (r_pend_head) begin
            r_cur <= head; r_prev <= NIL; r_steps <= '0;
        end else if (i_ctl.adv) begin
            r_prev <= r_cur; r_cur <= e_rd.nxt; r_steps <= r_steps + 1'b1;
            r_ent <= e_rd;
        end
        if (i_ctl.rd_head) begin
            r_cur <= NIL;
        end
        if (i_ctl.lu_hit || i_ctl.hit) begin
            r_status <= ST_FOUND;
            r_fh <= i_ctl.lu_hit ? r_last[HW-1:0] : r_cur[HW-1:0];
            r_cnt <= e_wd.cnt;
        end
        if (i_ctl.miss && r_cmd == CMD_CREATE) begin
            if (r_free_total != '0 && r_free_head != NIL) begin
                r_status <= ST_CREATED; r_fh <= r_free_head[HW-1:0];
                r_cnt <= COUNT_BITS'(1);
            end else begin
                r_status <= ST_FULL;
            end
        end
        if (i_ctl.h_chk && e_rd.used) begin
            if (r_cmd == CMD_RELEASE) begin
                r_status <= ST_FOUND; r_fh <= r_h;
                r_cnt <= (e_rd.cnt != '0) ? e_rd.cnt - 1'b1 : e_rd.cnt;
            end else if (e_rd.key == r_key && e_rd.cnt != '0) begin
                r_status <= ST_BUSY; r_fh <= r_h; r_cnt <= e_rd.cnt;
            end
        end
        if (i_ctl.do_free) begin
            r_status <= ST_FREED; r_fh <= r_h; r_cnt <= '0;
        end
    end

    assign o_status       = r_status;
    assign o_found_handle = r_fh;
    assign o_use_count    = r_cnt;
    assign o_free_low     = ({1'b0, r_free_total} < {1'b0, i_thr}) & i_ctl.done
                            | ({1'b0, r_free_total} < {1'b0, i_thr}) & ~rd_any;

    // free count stays within the pool
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= PW'(POOL_ENTRIES)) else $error("free count overflow");
    // an empty free list has a zero count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head == NIL |-> r_free_total == '0) else $error("free list lost");
    // no command accepted during clearing
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_ctl.load) else $error("accept during clear");
endmodule
`default_nettype wire

// File: verif/lock_monitor_hash_table_tb.sv
// self-checking testbench for the lock monitor hash table
`timescale 1ns / 1ps
module lock_monitor_hash_table_tb;
    import lmht_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [1:0]            i_cmd;
    logic [31:0]           i_key;
    logic [HW-1:0]         i_handle;
    logic                  o_valid;
    logic                  i_ready;
    logic [2:0]            o_status;
    logic [HW-1:0]         o_found_handle;
    logic [COUNT_BITS-1:0] o_use_count;
    logic                  o_free_low;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [1:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    lock_monitor_hash_table u_dut (.*);

    typedef struct packed {
        logic [2:0]            status;
        logic [HW-1:0]         fh;
        logic [COUNT_BITS-1:0] cnt;
        logic                  low;
    } t_result;

    // shadow copy of the table
    logic [31:0]           tbl_key   [POOL_ENTRIES];
    logic [PW-1:0]         tbl_next  [POOL_ENTRIES];
    logic                  tbl_used  [POOL_ENTRIES];
    logic [COUNT_BITS-1:0] tbl_count [POOL_ENTRIES];
    logic [PW-1:0]         tbl_head  [BUCKETS];
    logic [PW-1:0]         tbl_free_head;
    int                    tbl_free_total;
    logic [PW-1:0]         tbl_last;
    int                    tbl_threshold;

    t_result     pending_results[$];
    logic [31:0] live_keys[$];
    int          fail_count;
    int          cycle_count;
    bit          stall_en;
    localparam int CYCLE_LIMIT = 2_000_000;

    function automatic logic [BW-1:0] hash_bucket(logic [31:0] k);
        logic [31:0] x;
        x = (k >> 2) ^ (k >> 10);
        return x[BW-1:0];
    endfunction

    function automatic logic [PW-1:0] search_key(logic [31:0] k);
        logic [PW-1:0] e;
        if (tbl_last < NIL && tbl_used[tbl_last[HW-1:0]] && tbl_key[tbl_last[HW-1:0]] == k)
            return tbl_last;
        e = tbl_head[hash_bucket(k)];
        for (int s = 0; s < POOL_ENTRIES && e < NIL; s++) begin
            if (tbl_used[e[HW-1:0]] && tbl_key[e[HW-1:0]] == k) begin
                tbl_last = e;
                return e;
            end
            e = tbl_next[e[HW-1:0]];
        end
        return NIL;
    endfunction

    function automatic void detach_entry(logic [BW-1:0] b, logic [HW-1:0] h);
        logic [PW-1:0] prev, e;
        prev = NIL;
        e = tbl_head[b];
        for (int s = 0; s < POOL_ENTRIES && e < NIL; s++) begin
            if (e[HW-1:0] == h) begin
                if (prev == NIL) tbl_head[b] = tbl_next[h];
                else tbl_next[prev[HW-1:0]] = tbl_next[h];
                return;
            end
            prev = e;
            e = tbl_next[e[HW-1:0]];
        end
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < POOL_ENTRIES; i++) begin
            tbl_key[i] = '0;
            tbl_used[i] = 1'b0;
            tbl_count[i] = '0;
            tbl_next[i] = PW'(i + 1);
        end
        for (int i = 0; i < BUCKETS; i++) tbl_head[i] = NIL;
        tbl_free_head = '0;
        tbl_free_total = POOL_ENTRIES;
        tbl_last = NIL;
        tbl_threshold = 5;
    endfunction

    // expected result of one command, updating the shadow table
    function automatic t_result table_command(t_cmd c, logic [31:0] k, logic [HW-1:0] h);
        t_result r;
        logic [PW-1:0] e;
        logic [BW-1:0] b;
        r = '0;
        r.status = ST_NOT_FOUND;
        case (c)
            CMD_LOOKUP: begin
                e = search_key(k);
                if (e < NIL) begin
                    r.status = ST_FOUND;
                    r.fh = e[HW-1:0];
                    r.cnt = tbl_count[e[HW-1:0]];
                end
            end
            CMD_CREATE: begin
                e = search_key(k);
                if (e < NIL) begin
                    if (tbl_count[e[HW-1:0]] != COUNT_MAX)
                        tbl_count[e[HW-1:0]]++;
                    r.status = ST_FOUND;
                    r.fh = e[HW-1:0];
                    r.cnt = tbl_count[e[HW-1:0]];
                end else if (tbl_free_total == 0 || tbl_free_head >= NIL) begin
                    r.status = ST_FULL;
                end else begin
                    b = hash_bucket(k);
                    e = tbl_free_head;
                    tbl_free_head = tbl_next[e[HW-1:0]];
                    tbl_free_total--;
                    tbl_key[e[HW-1:0]] = k;
                    tbl_used[e[HW-1:0]] = 1'b1;
                    tbl_count[e[HW-1:0]] = COUNT_BITS'(1);
                    tbl_next[e[HW-1:0]] = tbl_head[b];
                    tbl_head[b] = e;
                    r.status = ST_CREATED;
                    r.fh = e[HW-1:0];
                    r.cnt = COUNT_BITS'(1);
                end
            end
            CMD_DESTROY: begin
                if (tbl_used[h] && tbl_key[h] == k) begin
                    if (tbl_count[h] != 0) begin
                        r.status = ST_BUSY;
                        r.fh = h;
                        r.cnt = tbl_count[h];
                    end else begin
                        detach_entry(hash_bucket(k), h);
                        tbl_key[h] = '0;
                        tbl_used[h] = 1'b0;
                        if (tbl_last == {1'b0, h}) tbl_last = NIL;
                        tbl_next[h] = tbl_free_head;
                        tbl_free_head = {1'b0, h};
                        tbl_free_total++;
                        r.status = ST_FREED;
                        r.fh = h;
                    end
                end
            end
            default: begin
                if (tbl_used[h]) begin
                    if (tbl_count[h] != 0) tbl_count[h]--;
                    r.status = ST_FOUND;
                    r.fh = h;
                    r.cnt = tbl_count[h];
                end
            end
        endcase
        r.low = (tbl_free_total < tbl_threshold);
        return r;
    endfunction

    // clock and cycle limit
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lock_monitor_hash_table_tb NOT OK");
            $finish;
        end
    end

    // result receiver with random stall bursts
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (stall_en && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 15) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction status %0d", o_status);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_status);
                    fail_count++;
                end
                if (o_found_handle !== exp_r.fh) begin
                    $error("found_handle expected %0d actual %0d", exp_r.fh, o_found_handle);
                    fail_count++;
                end
                if (o_use_count !== exp_r.cnt) begin
                    $error("use_count expected %0d actual %0d", exp_r.cnt, o_use_count);
                    fail_count++;
                end
                if (o_free_low !== exp_r.low) begin
                    $error("free_low expected %0d actual %0d", exp_r.low, o_free_low);
                    fail_count++;
                end
            end
        end
    end

    // send one command transaction, with an optional idle burst first
    task automatic send_command(t_cmd c, logic [31:0] k, logic [HW-1:0] h);
        t_result r;
        if (stall_en && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= c;
        i_key <= k;
        i_handle <= h;
        do @(posedge i_clk); while (!o_ready);
        r = table_command(c, k, h);
        pending_results.push_back(r);
        if (c == CMD_CREATE && r.status == ST_CREATED) live_keys.push_back(k);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [6:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {25'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tbl_threshold = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [HW-1:0] handle_of(logic [31:0] k);
        for (int i = 0; i < POOL_ENTRIES; i++)
            if (tbl_used[i] && tbl_key[i] == k) return HW'(i);
        return '0;
    endfunction

    // directed: extremes, every command and the special cases
    task automatic test_directed();
        send_command(CMD_LOOKUP, 32'h0, '0);
        send_command(CMD_CREATE, 32'h0, '0);
        send_command(CMD_CREATE, 32'hFFFF_FFFF, '1);
        send_command(CMD_CREATE, 32'h0000_0080, '0);
        send_command(CMD_LOOKUP, 32'hFFFF_FFFF, '0);
        send_command(CMD_LOOKUP, 32'h0, '0);
        send_command(CMD_CREATE, 32'h0, '0);
        send_command(CMD_DESTROY, 32'h0, 6'd0);
        send_command(CMD_DESTROY, 32'h1234, 6'd0);
        send_command(CMD_DESTROY, 32'h0, 6'd63);
        send_command(CMD_RELEASE, 32'hDEAD_BEEF, 6'd0);
        send_command(CMD_RELEASE, 32'h0, 6'd0);
        send_command(CMD_RELEASE, 32'h0, 6'd0);
        send_command(CMD_DESTROY, 32'h0, 6'd0);
        send_command(CMD_LOOKUP, 32'h0, '0);
        send_command(CMD_RELEASE, 32'h0, 6'd0);
        send_command(CMD_LOOKUP, 32'h0000_0080, '0);
        send_command(CMD_RELEASE, 32'h0, 6'd2);
        send_command(CMD_DESTROY, 32'h0000_0080, 6'd2);
        send_command(CMD_CREATE, 32'h5555_AAAA, 6'h2A);
        drain_results();
    endtask

    // fill the pool past full, then empty it again
    task automatic test_pool_full();
        logic [31:0] k;
        write_threshold(7'd64);
        for (int i = 0; i < POOL_ENTRIES + 3; i++)
            send_command(CMD_CREATE,
                         32'({$urandom_range(0, 255), 2'b00} << (i % 8)) ^ 32'(i), '0);
        while (live_keys.size() != 0) begin
            k = live_keys.pop_front();
            if (tbl_used[handle_of(k)] && tbl_key[handle_of(k)] == k) begin
                while (tbl_count[handle_of(k)] != 0)
                    send_command(CMD_RELEASE, $urandom, handle_of(k));
                send_command(CMD_DESTROY, k, handle_of(k));
            end
        end
        drain_results();
    endtask

    // random mix over a small key set so hits, chains and frees are common
    task automatic test_random(int n_items, logic [6:0] thr);
        logic [31:0] k;
        int sel;
        write_threshold(thr);
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) k = $urandom;
            else k = {4'($urandom_range(0, 3)), 20'd0, 6'($urandom_range(0, 47)),
                      2'($urandom)};
            if (sel < 35) send_command(CMD_CREATE, k, 6'($urandom));
            else if (sel < 55) send_command(CMD_LOOKUP, k, 6'($urandom));
            else if (sel < 75) send_command(CMD_RELEASE, $urandom, handle_of(k) ^
                                            (($urandom_range(0, 7) == 0) ? 6'($urandom) : '0));
            else if (sel < 95) send_command(CMD_DESTROY, k, handle_of(k));
            else send_command(t_cmd'($urandom_range(0, 3)), $urandom, 6'($urandom));
            if (stall_en && i == n_items / 2) begin
                // sender holds until every result is back
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
        end
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = '0;
        i_key = '0;
        i_handle = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        cycle_count = 0;
        stall_en = 1'b1;
        table_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pool_full();
        test_random(400, 7'd0);
        test_random(400, 7'd40);
        stall_en = 1'b0;
        test_random(150, 7'd5);
        if (fail_count == 0)
            $display("lock_monitor_hash_table_tb OK");
        else
            $display("lock_monitor_hash_table_tb NOT OK");
        $finish;
    end
endmodule

// File: sim.f
src/lmht_pkg.sv
src/lmht_ram.sv
src/lmht_ctrl.sv
src/lmht_dp.sv
src/lock_monitor_hash_table.sv
verif/lock_monitor_hash_table_tb.sv
